>>> src/mexp_pkg.sv
`timescale 1ns / 1ps

package mexp_pkg;

    // Operand and modulus width of the multiply-reduce unit
    localparam int MOD_W = 32;
    localparam int MOD_CNT_W = $clog2(MOD_W);

    // Exponent bits walked per word (8 to 32)
    localparam int WIDTH = 32;
    localparam int EXP_CNT_W = $clog2(WIDTH);

    // Width of the exponent field on the input channel
    localparam int EXP_FIELD_W = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_SQR,
        S_MUL,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic start;
        logic [MOD_W-1:0] opa;
        logic [MOD_W-1:0] opb;
    } mul_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

>>> src/mexp_in_if.sv
`timescale 1ns / 1ps

interface mexp_in_if;
    logic valid;
    logic ready;
    logic [mexp_pkg::MOD_W-1:0] base_value;
    logic [mexp_pkg::EXP_FIELD_W-1:0] exponent_value;

    modport source (output valid, output base_value, output exponent_value, input ready);
    modport sink (input valid, input base_value, input exponent_value, output ready);
endinterface

>>> src/mexp_out_if.sv
`timescale 1ns / 1ps

interface mexp_out_if;
    logic valid;
    logic ready;
    logic [mexp_pkg::MOD_W-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink (input valid, input power_result, output ready);
endinterface

>>> src/mexp_mulmod.sv
`timescale 1ns / 1ps

// Interleaved multiply-reduce: one multiplier bit per cycle, MSB first.
// r = 2r mod m, then r = r + a mod m on a one bit. Needs a < m, or m = 1.
module mexp_mulmod (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mexp_pkg::mul_cmd_t        cmd,
    input  logic [mexp_pkg::MOD_W-1:0] modulus,
    output mexp_pkg::mul_stat_t       stat,
    output logic [mexp_pkg::MOD_W-1:0] product
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [mexp_pkg::MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic [mexp_pkg::MOD_W-1:0]   r_reg, r_next;
    logic [mexp_pkg::MOD_W-1:0]   a_reg, a_next;
    logic [mexp_pkg::MOD_W-1:0]   b_reg, b_next;

    logic [mexp_pkg::MOD_W:0] m_ext;
    logic [mexp_pkg::MOD_W:0] dbl;
    logic [mexp_pkg::MOD_W:0] dbl_red;
    logic [mexp_pkg::MOD_W:0] sum;
    logic [mexp_pkg::MOD_W:0] sum_red;

    always_comb
    begin
        m_ext   = {1'b0, modulus};
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
        sum     = dbl_red + (b_reg[mexp_pkg::MOD_W-1] ? {1'b0, a_reg} : '0);
        sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (busy_reg)
        begin
            r_next = sum_red[mexp_pkg::MOD_W-1:0];
            b_next = {b_reg[mexp_pkg::MOD_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = mexp_pkg::MOD_CNT_W'(mexp_pkg::MOD_W - 1);
            r_next    = '0;
            a_next    = cmd.opa;
            b_next    = cmd.opb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = r_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("mulmod done while still busy");

    a_done_follows_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && $past(cnt_reg) == '0)
        else $error("mulmod done without finishing the bit walk");

    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> r_reg < modulus)
        else $error("mulmod result not reduced");

endmodule

>>> src/modular_exponentiation.sv
`timescale 1ns / 1ps

// Computes base_value ** exponent_value mod modulus by square-and-multiply,
// one word at a time. All arithmetic runs on one shared multiply-reduce unit
// that walks the 32 multiplier bits of each modular product in turn:
// one product reduces the base, then each of the low WIDTH exponent bits costs
// a squaring, plus a multiply on a one bit. A zero exponent returns 1 without
// using the unit. in_ch.ready is high only between words; a finished result
// waits in the output register while the next word is taken. A modulus of 0
// behaves as 1. Write the modulus only while idle.
module modular_exponentiation (
    input  logic                          clk,
    input  logic                          rst_n,
    mexp_in_if.sink                       in_ch,
    mexp_out_if.source                    out_ch,
    input  logic                          modulus_we,
    input  logic [mexp_pkg::MOD_W-1:0]    modulus_wdata
);

    mexp_pkg::seq_state_t state_reg, state_next;

    logic [mexp_pkg::MOD_W-1:0]     modulus_reg;
    logic [mexp_pkg::MOD_W-1:0]     m_eff;
    logic [mexp_pkg::MOD_W-1:0]     base_reg, base_next;
    logic [mexp_pkg::MOD_W-1:0]     acc_reg, acc_next;
    logic [mexp_pkg::WIDTH-1:0]     exp_reg, exp_next;
    logic [mexp_pkg::EXP_CNT_W-1:0] bit_reg, bit_next;
    logic                           out_valid_reg, out_valid_next;
    logic [mexp_pkg::MOD_W-1:0]     power_result_reg, power_result_next;

    mexp_pkg::mul_cmd_t             mul_cmd;
    mexp_pkg::mul_stat_t            mul_stat;
    logic [mexp_pkg::MOD_W-1:0]     mul_product;
    logic                           in_fire;
    logic [mexp_pkg::WIDTH-1:0]     in_exp;

    assign m_eff   = (modulus_reg == '0) ? mexp_pkg::MOD_W'(1) : modulus_reg;
    assign in_exp  = in_ch.exponent_value[mexp_pkg::WIDTH-1:0];
    assign in_fire = in_ch.valid && in_ch.ready;

    assign in_ch.ready         = (state_reg == mexp_pkg::S_IDLE);
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.power_result = power_result_reg;

    mexp_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mul_cmd),
        .modulus (m_eff),
        .stat    (mul_stat),
        .product (mul_product)
    );

    always_comb
    begin
        state_next        = state_reg;
        base_next         = base_reg;
        acc_next          = acc_reg;
        exp_next          = exp_reg;
        bit_next          = bit_reg;
        out_valid_next    = out_valid_reg && !out_ch.ready;
        power_result_next = power_result_reg;
        mul_cmd.start     = 1'b0;
        mul_cmd.opa       = acc_reg;
        mul_cmd.opb       = acc_reg;

        case (state_reg)
            mexp_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    exp_next = in_exp;
                    bit_next = mexp_pkg::EXP_CNT_W'(mexp_pkg::WIDTH - 1);
                    acc_next = mexp_pkg::MOD_W'(1);
                    if (in_exp == '0)
                    begin
                        state_next = mexp_pkg::S_DONE;
                    end
                    else
                    begin
                        // base mod m as 1 * base
                        mul_cmd.start = 1'b1;
                        mul_cmd.opa   = mexp_pkg::MOD_W'(1);
                        mul_cmd.opb   = in_ch.base_value;
                        state_next    = mexp_pkg::S_RED;
                    end
                end
            end

            mexp_pkg::S_RED:
            begin
                if (mul_stat.done)
                begin
                    base_next     = mul_product;
                    mul_cmd.start = 1'b1;
                    state_next    = mexp_pkg::S_SQR;
                end
            end

            mexp_pkg::S_SQR:
            begin
                if (mul_stat.done)
                begin
                    acc_next = mul_product;
                    if (exp_reg[bit_reg])
                    begin
                        mul_cmd.start = 1'b1;
                        mul_cmd.opa   = base_reg;
                        mul_cmd.opb   = mul_product;
                        state_next    = mexp_pkg::S_MUL;
                    end
                    else if (bit_reg == '0)
                    begin
                        state_next = mexp_pkg::S_DONE;
                    end
                    else
                    begin
                        bit_next      = bit_reg - 1'b1;
                        mul_cmd.start = 1'b1;
                        mul_cmd.opa   = mul_product;
                        mul_cmd.opb   = mul_product;
                    end
                end
            end

            mexp_pkg::S_MUL:
            begin
                if (mul_stat.done)
                begin
                    acc_next = mul_product;
                    if (bit_reg == '0)
                    begin
                        state_next = mexp_pkg::S_DONE;
                    end
                    else
                    begin
                        bit_next      = bit_reg - 1'b1;
                        mul_cmd.start = 1'b1;
                        mul_cmd.opa   = mul_product;
                        mul_cmd.opb   = mul_product;
                        state_next    = mexp_pkg::S_SQR;
                    end
                end
            end

            mexp_pkg::S_DONE:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next    = 1'b1;
                    power_result_next = acc_reg;
                    state_next        = mexp_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = mexp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mexp_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            modulus_reg   <= mexp_pkg::MOD_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (modulus_we)
            begin
                modulus_reg <= modulus_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg         <= base_next;
        acc_reg          <= acc_next;
        exp_reg          <= exp_next;
        bit_reg          <= bit_next;
        power_result_reg <= power_result_next;
    end

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        mul_cmd.start |-> !mul_stat.busy)
        else $error("multiply issued while unit busy");

    a_done_in_op_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.done |-> (state_reg == mexp_pkg::S_RED || state_reg == mexp_pkg::S_SQR
                           || state_reg == mexp_pkg::S_MUL))
        else $error("multiply result outside an operation state");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (power_result_reg < m_eff || power_result_reg == 1))
        else $error("result not reduced by the modulus");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int QUIET_LIMIT = 50000;
    localparam int LONG_HOLD = 6000;

    typedef struct packed {
        logic [mexp_pkg::MOD_W-1:0]       base;
        logic [mexp_pkg::EXP_FIELD_W-1:0] expo;
    } exp_word_t;

    logic clk = 1'b0;
    logic rst_n;
    logic modulus_we;
    logic [mexp_pkg::MOD_W-1:0] modulus_wdata;

    mexp_in_if  in_ch ();
    mexp_out_if out_ch ();

    modular_exponentiation i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .modulus_we    (modulus_we),
        .modulus_wdata (modulus_wdata)
    );

    always #4 clk = ~clk;

    exp_word_t                  pending_words[$];
    logic [mexp_pkg::MOD_W-1:0] expected_powers[$];
    logic [mexp_pkg::MOD_W-1:0] modulus_now;
    int                         mismatches;
    int                         results_seen;
    int                         burst_left;
    int                         gap_left;
    int                         hold_left;
    bit                         long_hold_done;
    int                         stall_mode;
    int                         mode_left;
    int                         quiet_cycles;

    int primes[7] = '{61, 53, 257, 4093, 8191, 65519, 65521};

    // square-and-multiply over the low WIDTH exponent bits, modulus 0 taken as 1
    function automatic logic [mexp_pkg::MOD_W-1:0] mod_power(
        input logic [mexp_pkg::MOD_W-1:0]       b,
        input logic [mexp_pkg::EXP_FIELD_W-1:0] e,
        input logic [mexp_pkg::MOD_W-1:0]       m);
        logic [63:0] mm;
        logic [63:0] rb;
        logic [63:0] acc;
        logic [63:0] ew;
        mm = (m == '0) ? 64'd1 : 64'(m);
        ew = 64'(e) & ((64'd1 << mexp_pkg::WIDTH) - 64'd1);
        rb = 64'(b) % mm;
        if (ew == 64'd0)
        begin
            return mexp_pkg::MOD_W'(1);
        end
        acc = 64'd1;
        for (int i = mexp_pkg::WIDTH - 1; i >= 0; i--)
        begin
            acc = (acc * acc) % mm;
            if (ew[i])
            begin
                acc = (acc * rb) % mm;
            end
        end
        return acc[mexp_pkg::MOD_W-1:0];
    endfunction

    task automatic queue_word(input logic [mexp_pkg::MOD_W-1:0] b,
                              input logic [mexp_pkg::EXP_FIELD_W-1:0] e);
        exp_word_t w;
        w.base = b;
        w.expo = e;
        pending_words.push_back(w);
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || expected_powers.size() != 0 || in_ch.valid)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_modulus(input logic [mexp_pkg::MOD_W-1:0] value);
        wait_drained();
        @(posedge clk);
        modulus_we <= 1'b1;
        modulus_wdata <= value;
        modulus_now <= value;
        @(posedge clk);
        modulus_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic queue_random(input int count);
        logic [mexp_pkg::MOD_W-1:0]       b;
        logic [mexp_pkg::EXP_FIELD_W-1:0] e;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 9))
                0: b = '0;
                1: b = '1;
                2: b = modulus_now - 1;
                3: b = $urandom_range(0, 16);
                default: b = $urandom;
            endcase
            case ($urandom_range(0, 11))
                0: e = '0;
                1: e = $urandom_range(1, 16);
                2: e = '1;
                3: e = 1 << $urandom_range(0, mexp_pkg::EXP_FIELD_W - 1);
                default: e = $urandom;
            endcase
            queue_word(b, e);
        end
    endtask

    // sender: bursts of words with random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        exp_word_t nxt;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.base_value <= '0;
            in_ch.exponent_value <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_powers.push_back(mod_power(in_ch.base_value, in_ch.exponent_value,
                                                    modulus_now));
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    nxt = pending_words.pop_front();
                    in_ch.base_value <= nxt.base;
                    in_ch.exponent_value <= nxt.expo;
                    in_ch.valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 6);
                        case ($urandom_range(0, 3))
                            0: gap_left <= 0;
                            1: gap_left <= $urandom_range(1, 3000);
                            default: gap_left <= $urandom_range(1, 20);
                        endcase
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern, plus one long hold-off while words are still queued
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_left <= 0;
            long_hold_done <= 1'b0;
            stall_mode <= 0;
            mode_left <= 0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (!long_hold_done && results_seen >= 40 && pending_words.size() > 3)
        begin
            hold_left <= LONG_HOLD;
            long_hold_done <= 1'b1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(20, 400);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 1) == 0);
                default: out_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic [mexp_pkg::MOD_W-1:0] want;
        if (!rst_n)
        begin
            mismatches <= 0;
            results_seen <= 0;
        end
        else if (out_ch.valid && out_ch.ready)
        begin
            results_seen <= results_seen + 1;
            if (expected_powers.size() == 0)
            begin
                $display("%0t: power_result %h with no word outstanding", $time,
                         out_ch.power_result);
                mismatches <= mismatches + 1;
            end
            else
            begin
                want = expected_powers.pop_front();
                if (out_ch.power_result !== want)
                begin
                    $display("%0t: power_result expected %h, got %h", $time, want,
                             out_ch.power_result);
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("modular_exponentiation: mismatch");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int p;
        int q;
        rst_n <= 1'b0;
        modulus_we <= 1'b0;
        modulus_wdata <= '0;
        modulus_now <= 1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // modulus still at its reset value of one
        queue_word(32'd5, 32'd0);
        queue_word(32'd5, 32'd1);
        queue_word('1, '1);
        queue_word('0, '0);

        set_modulus('1);
        queue_word('0, '0);
        queue_word('0, 32'd5);
        queue_word(32'd1, '1);
        queue_word('1, 32'd1);
        queue_word(32'hFFFF_FFFE, 32'd2);
        queue_word(32'hFFFF_FFFE, '1);
        queue_word(32'd2, 32'd31);
        queue_word(32'd2, 32'd32);
        queue_word(32'd3, 32'h8000_0000);
        queue_word(32'h1234_5678, 32'd1);
        queue_word(32'hABCD_EF01, 32'hDEAD_BEEF);
        queue_word('1, '0);

        set_modulus(32'd3233);
        queue_word(32'd65, 32'd17);
        queue_word(32'd2790, 32'd2753);
        queue_word(32'd3233, 32'd5);
        queue_word(32'd3234, 32'd1);
        queue_word(32'd3232, 32'd2);

        // zero modulus acts as one
        set_modulus('0);
        queue_word(32'd7, 32'd0);
        queue_word(32'd7, 32'd3);
        queue_word('0, '0);

        set_modulus(32'd1);
        queue_word(32'd9, 32'd0);
        queue_word(32'd9, '1);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    p = primes[$urandom_range(0, 6)];
                    q = primes[$urandom_range(0, 6)];
                    set_modulus(mexp_pkg::MOD_W'(p * q));
                end
                1: set_modulus($urandom);
                2: set_modulus($urandom_range(2, 300));
                default: set_modulus(32'h8000_0000 | $urandom);
            endcase
            queue_random(31);
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("modular_exponentiation: match");
        end
        else
        begin
            $display("modular_exponentiation: mismatch");
        end
        $finish;
    end

endmodule
